[src/sspcp_pkg.sv]
// Package: shared constants, types and helper functions of the setpoint command parser.
`default_nettype none
package sspcp_pkg;

  // Number of value characters that follow the '=' of a command.
  localparam int DATA_CHARS = 3;
  localparam int CNT_W      = (DATA_CHARS > 1) ? $clog2(DATA_CHARS) : 1;

  localparam int CHAR_W     = 8;
  localparam int CMD_W      = 3;
  localparam int SETTING_W  = 12;

  // Digit accumulator saturates here; wide enough for any DATA_CHARS in range.
  localparam int ACC_CAP    = 100000;
  localparam int ACC_W      = 17;
  localparam int VAL_W      = 21;

  localparam int MODE_OFFSET = 1000;
  localparam int SET_MAX     = (1 << (SETTING_W - 1)) - 1;
  localparam int SET_MIN     = -(1 << (SETTING_W - 1));

  localparam logic [CMD_W-1:0] CMD_MODE    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CURRENT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ANGLE   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SPEED   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DAMPING = 3'd4;
  localparam logic [CMD_W-1:0] CMD_GEAR    = 3'd5;

  localparam logic [CHAR_W-1:0] CH_EQUAL = 8'h3d;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;

  typedef logic [CHAR_W-1:0] char_t;
  typedef char_t data_chars_t [DATA_CHARS];

  // One registered input byte on its way to the decoder.
  typedef struct packed {
    logic  valid;
    char_t rx_char;
  } byte_stage_t;

  typedef struct packed {
    logic             hit;
    logic [CMD_W-1:0] code;
  } letter_t;

  function automatic letter_t decode_letter(input char_t c);
    letter_t res;
    res.hit  = 1'b1;
    res.code = CMD_MODE;
    case (c)
      8'h4d, 8'h6d: res.code = CMD_MODE;
      8'h43, 8'h63: res.code = CMD_CURRENT;
      8'h41, 8'h61: res.code = CMD_ANGLE;
      8'h53, 8'h73: res.code = CMD_SPEED;
      8'h44, 8'h64: res.code = CMD_DAMPING;
      8'h47, 8'h67: res.code = CMD_GEAR;
      default:      res.hit  = 1'b0;
    endcase
    return res;
  endfunction

  function automatic logic is_space(input char_t c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(input char_t c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // Converts the collected characters as atoi does, adds the mode offset for a mode command and
  // saturates to the width of the setting field.
  function automatic logic signed [SETTING_W-1:0] parse_setting(
    input data_chars_t chars,
    input logic        is_mode
  );
    logic [1:0]              scan;  // 0 skipping blanks, 1 reading digits, 2 stopped
    logic                    neg;
    logic [ACC_W-1:0]        acc;
    logic [VAL_W-1:0]        prod;
    logic signed [VAL_W-1:0] value;
    scan = 2'd0;
    neg  = 1'b0;
    acc  = '0;
    for (int i = 0; i < DATA_CHARS; i++) begin
      prod = ({{(VAL_W-ACC_W){1'b0}}, acc} << 3) + ({{(VAL_W-ACC_W){1'b0}}, acc} << 1)
           + {{(VAL_W-CHAR_W){1'b0}}, (chars[i] - CH_ZERO)};
      case (scan)
        2'd0: begin
          if (is_space(chars[i])) begin
            scan = 2'd0;
          end else if ((chars[i] == CH_PLUS) || (chars[i] == CH_MINUS)) begin
            neg  = (chars[i] == CH_MINUS);
            scan = 2'd1;
          end else if (is_digit(chars[i])) begin
            acc  = ACC_W'(chars[i] - CH_ZERO);
            scan = 2'd1;
          end else begin
            scan = 2'd2;
          end
        end
        2'd1: begin
          if (is_digit(chars[i])) begin
            acc = (prod > VAL_W'(ACC_CAP)) ? ACC_W'(ACC_CAP) : prod[ACC_W-1:0];
          end else begin
            scan = 2'd2;
          end
        end
        default: scan = 2'd2;
      endcase
    end
    value = $signed({{(VAL_W-ACC_W){1'b0}}, acc});
    if (neg) begin
      value = -value;
    end
    if (is_mode) begin
      value = value + VAL_W'(MODE_OFFSET);
    end
    if (value > VAL_W'(SET_MAX)) begin
      value = VAL_W'(SET_MAX);
    end else if (value < $signed(VAL_W'(SET_MIN))) begin
      value = VAL_W'(SET_MIN);
    end
    return value[SETTING_W-1:0];
  endfunction

endpackage
`default_nettype wire

[src/sspcp_if.sv]
// Interfaces: the byte input channel and the parsed command result channel.
`default_nettype none
interface sspcp_in_if;
  import sspcp_pkg::*;
  logic  valid;
  logic  ready;
  char_t rx_char;

  modport source (output valid, output rx_char, input ready);
  modport sink   (input valid, input rx_char, output ready);
endinterface

interface sspcp_out_if;
  import sspcp_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [CMD_W-1:0]            command;
  logic signed [SETTING_W-1:0] setting;

  modport source (output valid, output command, output setting, input ready);
  modport sink   (input valid, input command, input setting, output ready);
endinterface
`default_nettype wire

[src/serial_setpoint_command_parser_unit.sv]
// Channels: in_ch carries one received ASCII byte per item (rx_char); out_ch
// carries one parsed command per item (command code and signed setting).
// Both use valid/ready; an item moves at a clock edge where both are high.
// A command is a letter M, C, A, S, D or G in either case, then '=', then
// three value characters, converted as atoi does. The mode command adds 1000.
// The result is presented on out_ch after the last value character has passed
// through the input register and then the result register; a stalled result
// ahead of it holds that character in the input register.
// Throughput: one byte per cycle while out_ch does not stall, set by the single
// decoder pass between the input register and the result register.
// When the receiver stalls, the result register holds its item, the input
// register holds one more byte and then in_ch.ready drops; nothing is lost.
// Reset (rst_n low at a clock edge) empties both registers and returns the
// parser to waiting for a command letter.
`default_nettype none
module serial_setpoint_command_parser_unit
  import sspcp_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  sspcp_in_if.sink    in_ch,
  sspcp_out_if.source out_ch
);

  byte_stage_t stage;
  logic        take;

  sspcp_input_stage u_input_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_rx_char (in_ch.rx_char),
    .in_ready   (in_ch.ready),
    .take       (take),
    .stage      (stage)
  );

  sspcp_decoder u_decoder (
    .clk         (clk),
    .rst_n       (rst_n),
    .stage       (stage),
    .take        (take),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_command (out_ch.command),
    .out_setting (out_ch.setting)
  );

endmodule
`default_nettype wire

[src/sspcp_input_stage.sv]
// Input register: holds one received byte until the decoder takes it.
`default_nettype none
module sspcp_input_stage
  import sspcp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire char_t       in_rx_char,
  output logic             in_ready,
  input  wire logic        take,
  output byte_stage_t      stage
);

  logic  valid_r;
  logic  valid_nxt;
  char_t char_r;

  // The register refills in the same cycle that the decoder takes its byte.
  assign in_ready  = !valid_r || take;
  assign valid_nxt = (in_valid && in_ready) ? 1'b1 : (take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      char_r <= in_rx_char;
    end
  end

  assign stage.valid   = valid_r;
  assign stage.rx_char = char_r;

endmodule
`default_nettype wire

[src/sspcp_decoder.sv]
// Decoder: command sequencer, value conversion and the result register.
`default_nettype none
module sspcp_decoder
  import sspcp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire byte_stage_t           stage,
  output logic                       take,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [CMD_W-1:0]           out_command,
  output logic signed [SETTING_W-1:0] out_setting
);

  localparam logic [1:0] PH_LETTER = 2'd0;
  localparam logic [1:0] PH_EQUAL  = 2'd1;
  localparam logic [1:0] PH_DATA   = 2'd2;

  logic [1:0]                  phase_r, phase_nxt;
  logic [CMD_W-1:0]            code_r, code_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  data_chars_t                 data_r;
  data_chars_t                 chars_in;
  logic                        out_valid_r, out_valid_nxt;
  logic [CMD_W-1:0]            command_r;
  logic signed [SETTING_W-1:0] setting_r;
  logic                        result_load;
  letter_t                     letter;

  // A byte moves on whenever the result register is free or being emptied.
  assign take   = stage.valid && (!out_valid_r || out_ready);
  assign letter = decode_letter(stage.rx_char);

  // The collected characters with the current byte shifted in as the newest.
  always_comb begin
    for (int i = 0; i < DATA_CHARS - 1; i++) begin
      chars_in[i] = data_r[i+1];
    end
    chars_in[DATA_CHARS-1] = stage.rx_char;
  end

  always_comb begin
    phase_nxt   = phase_r;
    code_nxt    = code_r;
    count_nxt   = count_r;
    result_load = 1'b0;
    if (take) begin
      case (phase_r)
        PH_EQUAL: begin
          count_nxt = '0;
          phase_nxt = (stage.rx_char == CH_EQUAL) ? PH_DATA : PH_LETTER;
        end
        PH_DATA: begin
          if (count_r == CNT_W'(DATA_CHARS - 1)) begin
            result_load = 1'b1;
            phase_nxt   = PH_LETTER;
            count_nxt   = '0;
          end else begin
            count_nxt = count_r + 1'b1;
          end
        end
        default: begin
          phase_nxt = PH_LETTER;
          if (letter.hit) begin
            code_nxt  = letter.code;
            count_nxt = '0;
            phase_nxt = PH_EQUAL;
          end
        end
      endcase
    end
  end

  assign out_valid_nxt = result_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LETTER;
      code_r      <= CMD_MODE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      code_r      <= code_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && (phase_r == PH_DATA)) begin
      data_r <= chars_in;
    end
    if (result_load) begin
      command_r <= code_r;
      setting_r <= parse_setting(chars_in, code_r == CMD_MODE);
    end
  end

  assign out_valid   = out_valid_r;
  assign out_command = command_r;
  assign out_setting = setting_r;

`ifndef SYNTHESIS
  // A new result can only come from a byte taken while collecting data.
  a_result_from_data: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(phase_r == PH_DATA && take))
    else $error("result appeared without a completing data byte");

  // Completing a command always returns the parser to letter search.
  a_back_to_letter: assert property (@(posedge clk) disable iff (!rst_n)
    result_load |=> (phase_r == PH_LETTER) && (count_r == '0))
    else $error("parser did not return to letter search after a result");

  // While a result is stalled no byte may be consumed.
  a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> $stable(phase_r) && $stable(count_r))
    else $error("parser state changed while the result was stalled");
`endif

endmodule
`default_nettype wire
